// ===== hdl/psf_pkg.sv =====
// Shared types, constants and helpers for the polygon scanline span fill unit.
// No dependencies; every other file imports this package.
package psf_pkg;

    // Default sizing, handed to the top level as parameter defaults
    localparam int MAX_VERTICES_DEF = 32;
    localparam int FRAC_BITS_DEF    = 16;

    // At most this many visible spans are emitted per row step
    localparam int MAX_RESULTS = 16;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W     = 17;

    localparam logic [CFG_ADDR_W-1:0] CFG_CLIP_LEFT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLIP_RIGHT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLIP_TOP    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CLIP_BOTTOM = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_STEP    = 3'd4;

    localparam logic signed [31:0] CLIP_LEFT_RST   = 32'sd0;
    localparam logic signed [31:0] CLIP_RIGHT_RST  = 32'sh7fffffff;
    localparam logic signed [31:0] CLIP_TOP_RST    = 32'sd0;
    localparam logic signed [31:0] CLIP_BOTTOM_RST = 32'sh7fffffff;
    localparam logic [STEP_W-1:0]  ROW_STEP_RST    = 17'd6554;

    // Opcodes of an input beat
    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_ROW    = 1'b1;

    // Multiplier operand widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic              opcode;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic              last_vertex;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] span_left;
        logic signed [31:0] span_row;
        logic [30:0]       span_width;
        logic              span_valid;
        logic              last_of_row;
        logic              polygon_done;
    } t_out_beat;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_vertex;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_IDLE_OUT,
        ST_VS_A,
        ST_VS_AY,
        ST_VS_B,
        ST_VS_BI,
        ST_VS_BC,
        ST_F0,
        ST_F1,
        ST_F2,
        ST_F3,
        ST_F4,
        ST_E_A,
        ST_E_B,
        ST_E_C,
        ST_E_D,
        ST_E_R,
        ST_D_A,
        ST_D_B,
        ST_D_S,
        ST_D_W,
        ST_I_A,
        ST_I_D,
        ST_I_M,
        ST_S_A,
        ST_S_B,
        ST_S_C,
        ST_S_D,
        ST_P_A,
        ST_P_B,
        ST_P_C,
        ST_P_F,
        ST_A_A,
        ST_A_B,
        ST_A_C,
        ST_A_F
    } t_state;

    // Clamp a wide signed value into 32 bits signed
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh0_7fff_ffff) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sh0_8000_0000) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/psf_mul.sv =====
// Bit-serial signed multiplier, one multiplier bit per cycle, then a sign fix-up step.
// Depends on psf_pkg for the operand widths.
module psf_mul import psf_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic                      o_done,
    output logic signed [MUL_P_W-1:0] o_prod
);

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [MUL_P_W-1:0] r_acc;
    logic [MUL_P_W-1:0] r_mc;
    logic [MUL_B_W-1:0] r_mp;
    logic               r_neg;
    logic signed [MUL_P_W-1:0] r_prod;

    logic [MUL_A_W:0]   a_ext;
    logic [MUL_A_W:0]   a_mag;
    logic [MUL_B_W:0]   b_ext;
    logic [MUL_B_W:0]   b_mag;

    // Operand magnitudes
    always_comb begin
        a_ext = {i_a[MUL_A_W-1], i_a};
        a_mag = i_a[MUL_A_W-1] ? (~a_ext + 1'b1) : a_ext;
        b_ext = {i_b[MUL_B_W-1], i_b};
        b_mag = i_b[MUL_B_W-1] ? (~b_ext + 1'b1) : b_ext;
    end

    // Control: run for one step per multiplier bit, then finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(MUL_B_W)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Datapath: shift and add, then apply the sign
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_mc  <= MUL_P_W'(a_mag[MUL_A_W-1:0]);
            r_mp  <= b_mag[MUL_B_W-1:0];
            r_neg <= i_a[MUL_A_W-1] ^ i_b[MUL_B_W-1];
        end else if (r_busy) begin
            if (r_cnt == CNT_W'(MUL_B_W)) begin
                r_prod <= r_neg ? $signed(~r_acc + 1'b1) : $signed(r_acc);
            end else begin
                if (r_mp[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc <= {r_mc[MUL_P_W-2:0], 1'b0};
                r_mp <= {1'b0, r_mp[MUL_B_W-1:1]};
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// ===== hdl/psf_div.sv =====
// Restoring divider for edge slopes: (dx * 2^FRAC_BITS) / dy, truncated and saturated.
// Depends on psf_pkg for the FRAC_BITS default; one quotient bit per cycle.
module psf_div import psf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_dx,
    input  logic [31:0]        i_dy,
    output logic               o_done,
    output logic signed [31:0] o_quo
);

    localparam int NW    = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [31:0]       r_rem;
    logic [NW-1:0]     r_dq;
    logic [31:0]       r_den;
    logic              r_neg;
    logic signed [31:0] r_quo;

    logic [32:0] dx_mag;
    logic [32:0] trial;
    logic        fits;
    logic [32:0] trial_sub;

    always_comb begin
        dx_mag    = i_dx[32] ? (~i_dx + 1'b1) : i_dx;
        trial     = {r_rem, r_dq[NW-1]};
        fits      = trial >= {1'b0, r_den};
        trial_sub = trial - {1'b0, r_den};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(NW)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Datapath: shift in one quotient bit per step, then sign and clamp
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dq  <= {dx_mag[31:0], {FRAC_BITS{1'b0}}};
            r_den <= i_dy;
            r_neg <= i_dx[32];
        end else if (r_busy) begin
            if (r_cnt == CNT_W'(NW)) begin
                if (!r_neg && (r_dq > NW'(32'h7fffffff))) begin
                    r_quo <= 32'sh7fffffff;
                end else if (r_neg && (r_dq > NW'(32'h80000000))) begin
                    r_quo <= 32'sh80000000;
                end else if (r_neg) begin
                    r_quo <= $signed(~r_dq[31:0] + 1'b1);
                end else begin
                    r_quo <= $signed(r_dq[31:0]);
                end
            end else begin
                r_rem <= fits ? trial_sub[31:0] : trial[31:0];
                r_dq  <= {r_dq[NW-2:0], fits};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== hdl/polygon_scanline_span_fill_unit.sv =====
// Top level of the polygon scanline span fill unit: sequencer, vertex, order and edge stores.
// Depends on psf_pkg, psf_div and psf_mul.
//
// Usage: vertex beats (opcode 0) load one Q16.16 vertex each and give no result; the beat
// with last_vertex closes the polygon and, for two or more vertices, starts a vertex sort.
// Row beats (opcode 1) each give one to sixteen result beats for the current row, the final
// one flagged last_of_row, then advance the row. A row beat's work: each vertex passed; per
// edge insertion, the slope divider and then the serial multiplier; an insertion sort of
// the active edges through the edge store's single read port; emission per edge pair; and
// one multiplier pass per active edge to step it down a row. The multiplier sets the floor.
// The input is stalled from acceptance until that work ends. Results go through a single
// output register; a stalled receiver holds the sequencer in emission until it drains.
// Reset (synchronous, active low) leaves the block idle with no polygon: a row beat then
// answers with one invalid, last, done result. Configuration writes take effect at once.
module polygon_scanline_span_fill_unit import psf_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_beat,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int VI = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int JW = CW + 1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] slope;
        logic [VI-1:0]      id;
    } t_edge;

    // Stores
    t_vertex       r_vmem [MAX_VERTICES];
    logic [VI-1:0] r_smem [MAX_VERTICES];
    t_edge         r_emem [MAX_VERTICES];
    t_vertex       r_vrd;
    logic [VI-1:0] r_srd;
    t_edge         r_erd;

    // Configuration
    logic signed [31:0] r_clip_left, r_clip_right, r_clip_top, r_clip_bottom;
    logic [STEP_W-1:0]  r_step;

    // Control state
    t_state r_state, n_state;
    logic [CW-1:0] r_vcnt, n_vcnt;
    logic [CW-1:0] r_poly_n, n_poly_n;
    logic [CW-1:0] r_nsp, n_nsp;
    logic [CW-1:0] r_act, n_act;
    logic [CW-1:0] r_a, n_a;
    logic [CW-1:0] r_b, n_b;
    logic [CW-1:0] r_k, n_k;
    logic [JW-1:0] r_j, n_j;
    logic          r_done, n_done;
    logic          r_phase, n_phase;
    logic          r_pv, n_pv;
    logic [NRES_W-1:0] r_nres, n_nres;
    logic          r_ov, n_ov;
    logic signed [31:0] r_row, n_row;
    logic signed [31:0] r_end, n_end;

    // Working payload
    logic signed [31:0] r_ty, n_ty;
    logic [VI-1:0] r_tidx, n_tidx;
    logic [VI-1:0] r_v, n_v;
    logic [VI-1:0] r_id, n_id;
    logic signed [31:0] r_vx, n_vx, r_vy, n_vy;
    logic signed [31:0] r_ox, n_ox, r_oy, n_oy;
    logic signed [31:0] r_px, n_px, r_py, n_py;
    t_edge     r_t, n_t;
    logic signed [31:0] r_xl, n_xl;
    t_out_beat r_pend, n_pend;
    t_out_beat r_out, n_out;

    // Memory controls
    logic          vwe;
    logic [VI-1:0] vwa, vaddr;
    logic          swe;
    logic [VI-1:0] swa, saddr, swd;
    logic          ewe;
    logic [VI-1:0] ewa, eaddr;
    t_edge         ewd;

    // Shared units
    logic               div_start, div_done;
    logic signed [32:0] div_dx;
    logic [31:0]        div_dy;
    logic signed [31:0] div_quo;
    logic               mul_start, mul_done;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_prod;

    // Derived values
    logic               in_acc;
    logic               slot_free;
    logic [CW-1:0]      cnt_new;
    logic [VI-1:0]      prev_i, next_i;
    logic [CW-1:0]      v_ext;
    logic [STEP_W-1:0]  step_e;
    logic signed [32:0] nr33;
    logic signed [31:0] nrs;
    logic               done_c;
    logic [JW-1:0]      j1;
    logic               vid_other;
    logic signed [31:0] ix, iy, nx, ny;
    logic signed [31:0] sel_px, sel_py, sel_qx, sel_qy;
    logic signed [32:0] dy33;
    logic signed [31:0] xl_c, xr_c;
    logic signed [32:0] w33;
    logic               vis;
    logic signed [31:0] prod_x;
    logic               push;
    t_out_beat          push_beat;
    t_out_beat          span_beat;

    assign in_acc    = i_in_valid && (r_state == ST_IDLE);
    assign slot_free = !r_ov || !i_out_stall;

    always_comb begin
        cnt_new = (r_vcnt < CW'(MAX_VERTICES)) ? r_vcnt + 1'b1 : r_vcnt;
        v_ext   = CW'(r_v);
        prev_i  = (r_v != '0) ? r_v - 1'b1 : VI'(r_poly_n - 1'b1);
        next_i  = ((v_ext + 1'b1) < r_poly_n) ? r_v + 1'b1 : '0;
        step_e  = (r_step == '0) ? STEP_W'(1) : r_step;
        nr33    = 33'(r_row) + $signed({16'b0, step_e});
        nrs     = (nr33 > 33'sh0_7fffffff) ? 32'sh7fffffff : nr33[31:0];
        done_c  = nrs >= r_end;
        j1      = r_j + 1'b1;
        // Insertion endpoints: id side and neighbour side
        vid_other = !r_phase;
        ix = vid_other ? r_ox : r_vx;
        iy = vid_other ? r_oy : r_vy;
        nx = vid_other ? r_vx : r_ox;
        ny = vid_other ? r_vy : r_oy;
        if (iy < ny) begin
            sel_px = ix; sel_py = iy; sel_qx = nx; sel_qy = ny;
        end else begin
            sel_px = nx; sel_py = ny; sel_qx = ix; sel_qy = iy;
        end
        dy33 = 33'(sel_qy) - 33'(sel_py);
        // Span clipping
        xl_c = (r_xl < r_clip_left) ? r_clip_left : r_xl;
        xr_c = (r_erd.x > r_clip_right) ? r_clip_right : r_erd.x;
        w33  = 33'(xr_c) - 33'(xl_c);
        vis  = (xl_c <= xr_c) && (r_nres < NRES_W'(MAX_RESULTS));
        span_beat.span_left    = xl_c;
        span_beat.span_row     = r_row;
        span_beat.span_width   = w33[31] ? 31'h7fffffff : w33[30:0];
        span_beat.span_valid   = 1'b1;
        span_beat.last_of_row  = 1'b0;
        span_beat.polygon_done = done_c;
        prod_x = sat32(66'(mul_prod >>> FRAC_BITS) +
                       66'((r_state == ST_I_M) ? r_px : r_t.x));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_beat.opcode == OP_VERTEX) begin
                        if (i_in_beat.last_vertex && (cnt_new >= CW'(2))) begin
                            n_state = ST_VS_A;
                        end
                    end else if (r_done) begin
                        n_state = ST_IDLE_OUT;
                    end else begin
                        n_state = ST_E_A;
                    end
                end
            end
            ST_IDLE_OUT: if (slot_free) n_state = ST_IDLE;
            ST_VS_A:  n_state = (r_a == r_poly_n) ? ST_F0 : ST_VS_AY;
            ST_VS_AY: n_state = ST_VS_B;
            ST_VS_B:  n_state = (r_b == '0) ? ST_VS_A : ST_VS_BI;
            ST_VS_BI: n_state = ST_VS_BC;
            ST_VS_BC: n_state = (r_vrd.y > r_ty) ? ST_VS_B : ST_VS_A;
            ST_F0:    n_state = ST_F1;
            ST_F1:    n_state = ST_F2;
            ST_F2:    n_state = ST_F3;
            ST_F3:    n_state = ST_F4;
            ST_F4:    n_state = ST_IDLE;
            ST_E_A:   n_state = (r_nsp < r_poly_n) ? ST_E_B : ST_S_A;
            ST_E_B:   n_state = ST_E_C;
            ST_E_C:   n_state = (r_vrd.y > r_row) ? ST_S_A : ST_E_D;
            ST_E_D:   n_state = (r_vrd.y <= r_row) ? ST_D_A : ST_I_A;
            ST_E_R:   n_state = r_phase ? ST_E_A : ST_E_D;
            ST_D_A:   n_state = (JW'(r_act) <= r_j) ? ST_E_R : ST_D_B;
            ST_D_B:   n_state = (r_erd.id == r_id) ? ST_D_S : ST_D_A;
            ST_D_S:   n_state = (JW'(r_act) <= r_j) ? ST_E_R : ST_D_W;
            ST_D_W:   n_state = ST_D_S;
            ST_I_A: begin
                if (r_act >= CW'(MAX_VERTICES)) begin
                    n_state = ST_E_R;
                end else if (dy33 <= 33'sd0) begin
                    n_state = ST_E_R;
                end else begin
                    n_state = ST_I_D;
                end
            end
            ST_I_D:   if (div_done) n_state = ST_I_M;
            ST_I_M:   if (mul_done) n_state = ST_E_R;
            ST_S_A:   n_state = (r_k >= r_act) ? ST_P_A : ST_S_B;
            ST_S_B:   n_state = ST_S_C;
            ST_S_C:   n_state = (r_j == '0) ? ST_S_A : ST_S_D;
            ST_S_D:   n_state = (r_erd.x > r_t.x) ? ST_S_C : ST_S_A;
            ST_P_A:   n_state = (j1 >= JW'(r_act)) ? ST_P_F : ST_P_B;
            ST_P_B:   n_state = ST_P_C;
            ST_P_C:   if (!(vis && r_pv && !slot_free)) n_state = ST_P_A;
            ST_P_F:   if (slot_free) n_state = ST_A_A;
            ST_A_A:   n_state = (JW'(r_act) <= r_j) ? ST_A_F : ST_A_B;
            ST_A_B:   n_state = ST_A_C;
            ST_A_C:   if (mul_done) n_state = ST_A_A;
            ST_A_F:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath, store controls and shared-unit requests
    always_comb begin
        n_vcnt = r_vcnt;   n_poly_n = r_poly_n; n_nsp = r_nsp;   n_act = r_act;
        n_a = r_a;         n_b = r_b;           n_k = r_k;       n_j = r_j;
        n_done = r_done;   n_phase = r_phase;   n_pv = r_pv;     n_nres = r_nres;
        n_row = r_row;     n_end = r_end;       n_ty = r_ty;     n_tidx = r_tidx;
        n_v = r_v;         n_id = r_id;         n_vx = r_vx;     n_vy = r_vy;
        n_ox = r_ox;       n_oy = r_oy;         n_px = r_px;     n_py = r_py;
        n_t = r_t;         n_xl = r_xl;         n_pend = r_pend;
        vwe = 1'b0; vwa = r_vcnt[VI-1:0]; vaddr = '0;
        swe = 1'b0; swa = '0; swd = '0; saddr = '0;
        ewe = 1'b0; ewa = '0; ewd = r_t; eaddr = '0;
        div_start = 1'b0; div_dx = 33'(sel_qx) - 33'(sel_px); div_dy = dy33[31:0];
        mul_start = 1'b0; mul_a = r_erd.slope; mul_b = $signed({16'b0, step_e});
        push = 1'b0; push_beat = span_beat;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_beat.opcode == OP_VERTEX) begin
                        // Abort any scan, store the vertex, close on the last one
                        if (!r_done) begin
                            n_done = 1'b1;
                            n_act  = '0;
                        end
                        vwe = r_vcnt < CW'(MAX_VERTICES);
                        if (i_in_beat.last_vertex) begin
                            n_poly_n = cnt_new;
                            n_vcnt   = '0;
                            n_a      = '0;
                        end else begin
                            n_vcnt = cnt_new;
                        end
                    end else begin
                        n_pv   = 1'b0;
                        n_nres = '0;
                    end
                end
            end
            ST_IDLE_OUT: begin
                push_beat = '{span_left: 32'sd0, span_row: r_row, span_width: 31'd0,
                              span_valid: 1'b0, last_of_row: 1'b1, polygon_done: 1'b1};
                push = slot_free;
            end
            // Vertex insertion sort by y
            ST_VS_A:  vaddr = r_a[VI-1:0];
            ST_VS_AY: begin
                n_ty = r_vrd.y;
                n_b  = r_a;
            end
            ST_VS_B: begin
                if (r_b == '0) begin
                    swe = 1'b1; swa = '0; swd = r_a[VI-1:0];
                    n_a = r_a + 1'b1;
                end else begin
                    saddr = VI'(r_b - 1'b1);
                end
            end
            ST_VS_BI: begin
                n_tidx = r_srd;
                vaddr  = r_srd;
            end
            ST_VS_BC: begin
                swe = 1'b1; swa = r_b[VI-1:0];
                if (r_vrd.y > r_ty) begin
                    swd = r_tidx;
                    n_b = r_b - 1'b1;
                end else begin
                    swd = r_a[VI-1:0];
                    n_a = r_a + 1'b1;
                end
            end
            // Start and end rows
            ST_F0: saddr = '0;
            ST_F1: vaddr = r_srd;
            ST_F2: begin
                n_row = (r_clip_top > r_vrd.y) ? r_clip_top : r_vrd.y;
                saddr = VI'(r_poly_n - 1'b1);
            end
            ST_F3: vaddr = r_srd;
            ST_F4: begin
                n_end  = (r_clip_bottom < r_vrd.y) ? r_clip_bottom : r_vrd.y;
                n_act  = '0;
                n_nsp  = '0;
                n_done = 1'b0;
            end
            // Vertices reached by the current row
            ST_E_A: begin
                saddr = r_nsp[VI-1:0];
                n_k   = CW'(1);
            end
            ST_E_B: begin
                n_v   = r_srd;
                vaddr = r_srd;
            end
            ST_E_C: begin
                n_vx    = r_vrd.x;
                n_vy    = r_vrd.y;
                n_phase = 1'b0;
                vaddr   = prev_i;
            end
            ST_E_D: begin
                n_id = r_phase ? r_v : prev_i;
                n_ox = r_vrd.x;
                n_oy = r_vrd.y;
                n_j  = '0;
            end
            ST_E_R: begin
                if (!r_phase) begin
                    n_phase = 1'b1;
                    vaddr   = next_i;
                end else begin
                    n_nsp = r_nsp + 1'b1;
                end
            end
            // Retire an edge and close the gap
            ST_D_A: eaddr = r_j[VI-1:0];
            ST_D_B: begin
                if (r_erd.id == r_id) begin
                    n_act = r_act - 1'b1;
                end else begin
                    n_j = j1;
                end
            end
            ST_D_S: eaddr = j1[VI-1:0];
            ST_D_W: begin
                ewe = 1'b1; ewa = r_j[VI-1:0]; ewd = r_erd;
                n_j = j1;
            end
            // Insert an edge with its slope and starting x
            ST_I_A: begin
                n_px = sel_px;
                n_py = sel_py;
                if (r_act < CW'(MAX_VERTICES)) begin
                    if (dy33 <= 33'sd0) begin
                        ewe   = 1'b1; ewa = r_act[VI-1:0];
                        ewd   = '{x: sel_px, slope: 32'sd0, id: r_id};
                        n_act = r_act + 1'b1;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_I_D: begin
                n_t.slope = div_quo;
                mul_a     = div_quo;
                mul_b     = 33'(r_row) - 33'(r_py);
                mul_start = div_done;
            end
            ST_I_M: begin
                if (mul_done) begin
                    ewe   = 1'b1; ewa = r_act[VI-1:0];
                    ewd   = '{x: prod_x, slope: r_t.slope, id: r_id};
                    n_act = r_act + 1'b1;
                end
            end
            // Insertion sort of active edges by x; start emission from the first pair
            ST_S_A: begin
                eaddr = r_k[VI-1:0];
                if (r_k >= r_act) begin
                    n_j = '0;
                end
            end
            ST_S_B: begin
                n_t = r_erd;
                n_j = JW'(r_k);
            end
            ST_S_C: begin
                if (r_j == '0) begin
                    ewe = 1'b1; ewa = '0; ewd = r_t;
                    n_k = r_k + 1'b1;
                end else begin
                    eaddr = VI'(r_j - 1'b1);
                end
            end
            ST_S_D: begin
                ewe = 1'b1; ewa = r_j[VI-1:0];
                if (r_erd.x > r_t.x) begin
                    ewd = r_erd;
                    n_j = r_j - 1'b1;
                end else begin
                    ewd = r_t;
                    n_k = r_k + 1'b1;
                end
            end
            // Emit spans pairwise; hold one back to mark the last
            ST_P_A: eaddr = r_j[VI-1:0];
            ST_P_B: begin
                n_xl  = r_erd.x;
                eaddr = j1[VI-1:0];
            end
            ST_P_C: begin
                eaddr = j1[VI-1:0];
                if (!(vis && r_pv && !slot_free)) begin
                    if (vis) begin
                        push      = r_pv;
                        push_beat = r_pend;
                        n_pend    = span_beat;
                        n_pv      = 1'b1;
                        n_nres    = r_nres + 1'b1;
                    end
                    n_j = r_j + JW'(2);
                end
            end
            ST_P_F: begin
                if (r_pv) begin
                    push_beat             = r_pend;
                    push_beat.last_of_row = 1'b1;
                end else begin
                    push_beat = '{span_left: 32'sd0, span_row: r_row, span_width: 31'd0,
                                  span_valid: 1'b0, last_of_row: 1'b1, polygon_done: done_c};
                end
                push = slot_free;
                n_j  = '0;
            end
            // Step every edge down one row
            ST_A_A: eaddr = r_j[VI-1:0];
            ST_A_B: begin
                n_t       = r_erd;
                mul_start = 1'b1;
            end
            ST_A_C: begin
                if (mul_done) begin
                    ewe = 1'b1; ewa = r_j[VI-1:0];
                    ewd = '{x: prod_x, slope: r_t.slope, id: r_t.id};
                    n_j = j1;
                end
            end
            ST_A_F: begin
                n_row = nrs;
                if (done_c) begin
                    n_done = 1'b1;
                    n_act  = '0;
                end
            end
            default: begin
            end
        endcase
        n_ov  = push ? 1'b1 : (i_out_stall ? r_ov : 1'b0);
        n_out = push ? push_beat : r_out;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_vcnt   <= '0;
            r_poly_n <= '0;
            r_nsp    <= '0;
            r_act    <= '0;
            r_a      <= '0;
            r_b      <= '0;
            r_k      <= '0;
            r_j      <= '0;
            r_done   <= 1'b1;
            r_phase  <= 1'b0;
            r_pv     <= 1'b0;
            r_nres   <= '0;
            r_ov     <= 1'b0;
            r_row    <= 32'sd0;
            r_end    <= 32'sd0;
        end else begin
            r_state  <= n_state;
            r_vcnt   <= n_vcnt;
            r_poly_n <= n_poly_n;
            r_nsp    <= n_nsp;
            r_act    <= n_act;
            r_a      <= n_a;
            r_b      <= n_b;
            r_k      <= n_k;
            r_j      <= n_j;
            r_done   <= n_done;
            r_phase  <= n_phase;
            r_pv     <= n_pv;
            r_nres   <= n_nres;
            r_ov     <= n_ov;
            r_row    <= n_row;
            r_end    <= n_end;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_left   <= CLIP_LEFT_RST;
            r_clip_right  <= CLIP_RIGHT_RST;
            r_clip_top    <= CLIP_TOP_RST;
            r_clip_bottom <= CLIP_BOTTOM_RST;
            r_step        <= ROW_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CLIP_LEFT:   r_clip_left   <= $signed(i_cfg_data);
                CFG_CLIP_RIGHT:  r_clip_right  <= $signed(i_cfg_data);
                CFG_CLIP_TOP:    r_clip_top    <= $signed(i_cfg_data);
                CFG_CLIP_BOTTOM: r_clip_bottom <= $signed(i_cfg_data);
                CFG_ROW_STEP:    r_step        <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Working payload registers
    always_ff @(posedge i_clk) begin
        r_ty   <= n_ty;
        r_tidx <= n_tidx;
        r_v    <= n_v;
        r_id   <= n_id;
        r_vx   <= n_vx;
        r_vy   <= n_vy;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_px   <= n_px;
        r_py   <= n_py;
        r_t    <= n_t;
        r_xl   <= n_xl;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    // Vertex store
    always_ff @(posedge i_clk) begin
        if (vwe) begin
            r_vmem[vwa] <= '{x: i_in_beat.vertex_x, y: i_in_beat.vertex_y};
        end
        r_vrd <= r_vmem[vaddr];
    end

    // Sorted order store
    always_ff @(posedge i_clk) begin
        if (swe) begin
            r_smem[swa] <= swd;
        end
        r_srd <= r_smem[saddr];
    end

    // Active edge store
    always_ff @(posedge i_clk) begin
        if (ewe) begin
            r_emem[ewa] <= ewd;
        end
        r_erd <= r_emem[eaddr];
    end

    psf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dx    (div_dx),
        .i_dy    (div_dy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    psf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_ov;
    assign o_out_beat  = r_out;

    // Active edge count stays within the store
    a_act_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act <= CW'(MAX_VERTICES))
        else $error("active edge count beyond store depth");

    // An idle block with no polygon in progress keeps no active edges
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_state == ST_IDLE)) |-> (r_act == '0))
        else $error("active edges left while idle");

    // Multiplier answers only while the sequencer waits for it
    a_mul_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> ((r_state == ST_I_M) || (r_state == ST_A_C)))
        else $error("multiplier result with no waiting step");

    // A held result beat is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall) |=> (r_ov && $stable(r_out)))
        else $error("stalled result beat lost");

endmodule
